FILE: rtl/brf_pkg.sv
// Shared types, codes and constants of the bracketing root finder.
`timescale 1ns / 1ps

package brf_pkg;

  // Default data width and fixed-point format.
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FRACTION_BITS   = 16;

  // Field and register widths.
  localparam int TOL_W       = 31;
  localparam int ITER_W      = 16;
  localparam int STATUS_W    = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 31;

  // Tolerance reset is about 0.001 in the fixed-point format.
  localparam logic [TOL_W-1:0]  TOL_RESET      = TOL_W'(((1 << FRACTION_BITS) + 500) / 1000);
  localparam logic [ITER_W-1:0] MAX_ITER_RESET = ITER_W'(100);

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_METHOD    = 2'd0,
    REG_TOL_VALUE = 2'd1,
    REG_TOL_STEP  = 2'd2,
    REG_MAX_ITER  = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    METHOD_BISECT    = 1'b0,
    METHOD_FALSE_POS = 1'b1
  } method_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_PROBE        = 3'd0,
    ST_DONE         = 3'd1,
    ST_BAD_INTERVAL = 3'd2,
    ST_SAME_SIGNS   = 3'd3,
    ST_LIMIT        = 3'd4,
    ST_FLAT         = 3'd5,
    ST_IDLE         = 3'd6
  } status_t;

  typedef struct packed {
    method_t            method;
    logic [TOL_W-1:0]   tol_value;
    logic [TOL_W-1:0]   tol_step;
    logic [ITER_W-1:0]  max_iter;
  } cfg_t;

  // Sequencer of the top level.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_NEXT,
    S_LAUNCH,
    S_FPOS,
    S_EMIT
  } ctrl_state_t;

  // Sequencer of the false-position unit.
  typedef enum logic [2:0] {
    FP_IDLE,
    FP_MUL1,
    FP_MUL2,
    FP_ABS,
    FP_DIV,
    FP_SAT
  } fp_state_t;

  // Completion status from the false-position unit.
  typedef struct packed {
    logic done;
    logic flat;
  } fp_stat_t;

endpackage

FILE: rtl/brf_ifs.sv
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps

interface brf_in_if import brf_pkg::*; #(parameter int W = VALUE_WIDTH_DEF);
  logic                valid;
  logic                ready;
  logic                start_req;
  logic signed [W-1:0] left_end;
  logic signed [W-1:0] right_end;
  logic signed [W-1:0] left_value;
  logic signed [W-1:0] right_value;
  logic signed [W-1:0] probe_value;

  modport source (
    output valid, start_req, left_end, right_end, left_value, right_value, probe_value,
    input  ready
  );
  modport sink (
    input  valid, start_req, left_end, right_end, left_value, right_value, probe_value,
    output ready
  );
endinterface

interface brf_out_if import brf_pkg::*; #(parameter int W = VALUE_WIDTH_DEF);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] probe_point;
  logic [STATUS_W-1:0] status;
  logic [ITER_W-1:0]   iteration;

  modport source (
    output valid, probe_point, status, iteration,
    input  ready
  );
  modport sink (
    input  valid, probe_point, status, iteration,
    output ready
  );
endinterface

FILE: rtl/brf_cfg.sv
// Configuration register file with indexed write port.
`timescale 1ns / 1ps

module brf_cfg import brf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  // Decode the index and update one register per write.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.method    <= METHOD_BISECT;
      cfg.tol_value <= TOL_RESET;
      cfg.tol_step  <= TOL_RESET;
      cfg.max_iter  <= MAX_ITER_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_METHOD:    cfg.method    <= method_t'(cfg_data[0]);
        REG_TOL_VALUE: cfg.tol_value <= cfg_data[TOL_W-1:0];
        REG_TOL_STEP:  cfg.tol_step  <= cfg_data[TOL_W-1:0];
        REG_MAX_ITER:  cfg.max_iter  <= cfg_data[ITER_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: rtl/brf_fpos.sv
// Iterative false-position unit: two shift-add products and a restoring divide on one adder.
`timescale 1ns / 1ps

module brf_fpos import brf_pkg::*; #(
  parameter int W = VALUE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  input  logic signed [W-1:0] fa,
  input  logic signed [W-1:0] fb,
  output fp_stat_t            stat,
  output logic signed [W-1:0] point
);

  localparam int PW    = 2 * W;
  localparam int AW    = PW + 1;
  localparam int CNT_W = $clog2(PW);

  fp_state_t state, state_next;

  // Operand magnitudes and denominator, prepared when a request arrives.
  logic [W-1:0] mag_a_in, mag_b_in, mag_fa_in, mag_fb_in, dm_in;
  logic         den_neg_in, flat_in;

  // Datapath registers.
  logic [AW-1:0]    acc;
  logic [PW-1:0]    mc;
  logic [W-1:0]     mp;
  logic [W-1:0]     mag_b, mag_fa;
  logic             neg1, neg2;
  logic             den_neg;
  logic [W-1:0]     dm;
  logic [W-1:0]     rem;
  logic [PW-1:0]    qn;
  logic             nn;
  logic [CNT_W-1:0] cnt;
  logic             done, flat;

  // Shared adder/subtractor.
  logic [AW-1:0] au_x, au_y, au_sum;
  logic          au_sub;

  logic [W:0]          rem_sh;
  logic                div_ge;
  logic                q_ovf, q_neg;
  logic signed [W-1:0] sat_point;

  assign mag_a_in   = a[W-1]  ? (~a  + W'(1)) : a;
  assign mag_b_in   = b[W-1]  ? (~b  + W'(1)) : b;
  assign mag_fa_in  = fa[W-1] ? (~fa + W'(1)) : fa;
  assign mag_fb_in  = fb[W-1] ? (~fb + W'(1)) : fb;
  assign den_neg_in = fb < fa;
  assign dm_in      = den_neg_in ? W'(fa - fb) : W'(fb - fa);
  assign flat_in    = fa == fb;

  assign rem_sh = {rem, qn[PW-1]};

  // Operand selection for the shared adder.
  always_comb begin
    au_x   = '0;
    au_y   = '0;
    au_sub = 1'b0;
    case (state)
      FP_MUL1: begin
        au_x   = acc;
        au_y   = mp[0] ? {1'b0, mc} : '0;
        au_sub = mp[0] & neg1;
      end
      FP_MUL2: begin
        au_x   = acc;
        au_y   = mp[0] ? {1'b0, mc} : '0;
        au_sub = mp[0] & neg2;
      end
      FP_ABS: begin
        au_y   = acc;
        au_sub = 1'b1;
      end
      FP_DIV: begin
        au_x   = AW'(rem_sh);
        au_y   = AW'(dm);
        au_sub = 1'b1;
      end
      FP_SAT: begin
        au_y   = {1'b0, qn};
        au_sub = 1'b1;
      end
      default: begin
      end
    endcase
    au_sum = au_x + (au_sub ? ~au_y : au_y) + AW'(au_sub);
  end

  assign div_ge = ~au_sum[AW-1];

  // Sign and saturation of the quotient.
  assign q_ovf = |qn[PW-1:W-1];
  assign q_neg = (nn != den_neg) && (|qn);
  always_comb begin
    if (q_neg) begin
      sat_point = q_ovf ? {1'b1, {(W-1){1'b0}}} : au_sum[W-1:0];
    end else begin
      sat_point = q_ovf ? {1'b0, {(W-1){1'b1}}} : qn[W-1:0];
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FP_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      FP_IDLE: if (start && !flat_in) state_next = FP_MUL1;
      FP_MUL1: if (mp == '0) state_next = FP_MUL2;
      FP_MUL2: if (mp == '0) state_next = FP_ABS;
      FP_ABS:  state_next = FP_DIV;
      FP_DIV:  if (cnt == CNT_W'(PW - 1)) state_next = FP_SAT;
      FP_SAT:  state_next = FP_IDLE;
      default: state_next = FP_IDLE;
    endcase
  end

  // Completion pulse; a zero denominator finishes at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      flat <= 1'b0;
    end else begin
      done <= (state == FP_SAT) || (state == FP_IDLE && start && flat_in);
      flat <= state == FP_IDLE && start && flat_in;
    end
  end

  // Datapath: the numerator accumulates as a signed sum of both products.
  always_ff @(posedge clk) begin
    case (state)
      FP_IDLE: begin
        if (start) begin
          acc     <= '0;
          mc      <= PW'(mag_a_in);
          mp      <= mag_fb_in;
          mag_b   <= mag_b_in;
          mag_fa  <= mag_fa_in;
          neg1    <= a[W-1] ^ fb[W-1];
          neg2    <= ~(b[W-1] ^ fa[W-1]);
          den_neg <= den_neg_in;
          dm      <= dm_in;
        end
      end
      FP_MUL1: begin
        if (mp == '0) begin
          mc <= PW'(mag_b);
          mp <= mag_fa;
        end else begin
          acc <= au_sum;
          mc  <= mc << 1;
          mp  <= mp >> 1;
        end
      end
      FP_MUL2: begin
        if (mp != '0) begin
          acc <= au_sum;
          mc  <= mc << 1;
          mp  <= mp >> 1;
        end
      end
      FP_ABS: begin
        nn  <= acc[AW-1];
        qn  <= acc[AW-1] ? au_sum[PW-1:0] : acc[PW-1:0];
        rem <= '0;
        cnt <= '0;
      end
      FP_DIV: begin
        rem <= div_ge ? au_sum[W-1:0] : rem_sh[W-1:0];
        qn  <= {qn[PW-2:0], div_ge};
        cnt <= cnt + 1'b1;
      end
      FP_SAT: begin
        point <= sat_point;
      end
      default: begin
      end
    endcase
  end

  assign stat = '{done: done, flat: flat};

endmodule

FILE: rtl/bracketing_root_finder_core.sv
// Top level of the bracketing root finder: sequencer, bracket state and output register.
//
//   Port       Dir   Handshake     Beat contents
//   item       in    valid/ready   start_req, left_end, right_end, left_value,
//                                  right_value, probe_value
//   result     out   valid/ready   probe_point, status, iteration
//   cfg_*      in    cfg_we only   cfg_index, cfg_data
//
// One item at a time. Status-only answers and bisection items are handled by the
// sequencer alone. Regula falsi items also wait for the false-position unit, which
// forms the shift-add products and the restoring divide on its one adder. The result
// register lets the next item in while a result beat still waits. Reset is synchronous
// and active high and leaves no problem running.
`timescale 1ns / 1ps

module bracketing_root_finder_core import brf_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  brf_in_if.sink                 item,
  brf_out_if.source              result
);

  localparam int W     = VALUE_WIDTH;
  localparam int CMP_W = (W > TOL_W) ? W : TOL_W;

  ctrl_state_t state, state_next;
  cfg_t        cfg;
  logic        accept;

  // Latched input beat.
  logic                start_q;
  logic signed [W-1:0] a_q, b_q, fa_q, fb_q, pv_q;

  // Problem state.
  logic signed [W-1:0] bracket_left, bracket_right, left_fvalue, right_fvalue;
  logic signed [W-1:0] current_probe, previous_probe;
  logic [ITER_W-1:0]   iter_count;
  logic                active;

  // Pending result and output register.
  logic signed [W-1:0] res_point;
  status_t             res_status;
  logic [ITER_W-1:0]   res_iter;
  logic                out_valid;
  logic signed [W-1:0] out_point;
  status_t             out_status;
  logic [ITER_W-1:0]   out_iter;

  // False-position unit handshake.
  logic                fp_start;
  fp_stat_t            fp_stat;
  logic signed [W-1:0] fp_point;

  // Decision signals.
  logic                bad_interval, ends_opposite, narrow_right;
  logic [W-1:0]        fc_mag, step_mag;
  logic signed [W-1:0] sel_x, sel_y;
  logic [W:0]          d1, d2, mid_sum;
  logic                value_conv, step_conv, converged, limit_hit;
  logic [ITER_W-1:0]   iter_inc;
  logic signed [W-1:0] mid_point;
  logic                out_free;

  brf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  brf_fpos #(.W(W)) u_fpos (
    .clk   (clk),
    .rst   (rst),
    .start (fp_start),
    .a     (bracket_left),
    .b     (bracket_right),
    .fa    (left_fvalue),
    .fb    (right_fvalue),
    .stat  (fp_stat),
    .point (fp_point)
  );

  assign item.ready = state == S_IDLE;
  assign accept     = item.valid && item.ready;
  assign out_free   = !out_valid || result.ready;

  // Start checks: ordered ends and strictly opposite end values.
  assign bad_interval  = !(a_q < b_q);
  assign ends_opposite = (fa_q[W-1] && !fb_q[W-1] && (|fb_q)) ||
                         (fb_q[W-1] && !fa_q[W-1] && (|fa_q));

  // Convergence on the probe value and on the step size.
  assign fc_mag     = pv_q[W-1] ? (~pv_q + W'(1)) : pv_q;
  assign value_conv = CMP_W'(fc_mag) < CMP_W'(cfg.tol_value);
  assign sel_x      = (cfg.method == METHOD_FALSE_POS) ? current_probe  : bracket_right;
  assign sel_y      = (cfg.method == METHOD_FALSE_POS) ? previous_probe : bracket_left;
  assign d1         = {sel_x[W-1], sel_x} - {sel_y[W-1], sel_y};
  assign d2         = {sel_y[W-1], sel_y} - {sel_x[W-1], sel_x};
  assign step_mag   = d1[W] ? d2[W-1:0] : d1[W-1:0];
  assign step_conv  = CMP_W'(step_mag) < CMP_W'(cfg.tol_step);
  assign converged  = value_conv || step_conv;

  // Narrowing side, iteration count and limit.
  assign narrow_right = (left_fvalue[W-1] && !pv_q[W-1] && (|pv_q)) ||
                        (pv_q[W-1] && !left_fvalue[W-1] && (|left_fvalue));
  assign iter_inc     = iter_count + 1'b1;
  assign limit_hit    = iter_count >= cfg.max_iter;

  // Midpoint rounded toward minus infinity.
  assign mid_sum   = {bracket_left[W-1], bracket_left} + {bracket_right[W-1], bracket_right};
  assign mid_point = mid_sum[W:1];

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and unit launch.
  always_comb begin
    state_next = state;
    fp_start   = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (start_q) begin
          state_next = (bad_interval || !ends_opposite) ? S_EMIT : S_LAUNCH;
        end else if (!active || converged) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        state_next = limit_hit ? S_EMIT : S_LAUNCH;
      end
      S_LAUNCH: begin
        if (cfg.method == METHOD_FALSE_POS) begin
          fp_start   = 1'b1;
          state_next = S_FPOS;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_FPOS: begin
        if (fp_stat.done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state: problem running, iteration count, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      iter_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      case (state)
        S_CHECK: begin
          if (start_q) begin
            active     <= 1'b0;
            iter_count <= '0;
          end else if (active && converged) begin
            active <= 1'b0;
          end else if (active) begin
            iter_count <= iter_inc;
          end
        end
        S_NEXT: begin
          if (limit_hit) active <= 1'b0;
        end
        S_LAUNCH: begin
          if (cfg.method == METHOD_BISECT) active <= 1'b1;
        end
        S_FPOS: begin
          if (fp_stat.done) active <= !fp_stat.flat;
        end
        default: begin
        end
      endcase

      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: input latch, bracket update and result composition.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          start_q <= item.start_req;
          a_q     <= item.left_end;
          b_q     <= item.right_end;
          fa_q    <= item.left_value;
          fb_q    <= item.right_value;
          pv_q    <= item.probe_value;
        end
      end
      S_CHECK: begin
        if (start_q) begin
          bracket_left  <= a_q;
          bracket_right <= b_q;
          left_fvalue   <= fa_q;
          right_fvalue  <= fb_q;
          current_probe <= a_q;
          res_point     <= '0;
          res_iter      <= '0;
          res_status    <= bad_interval ? ST_BAD_INTERVAL : ST_SAME_SIGNS;
        end else if (!active) begin
          res_point  <= '0;
          res_iter   <= '0;
          res_status <= ST_IDLE;
        end else if (converged) begin
          res_point  <= current_probe;
          res_iter   <= iter_inc;
          res_status <= ST_DONE;
        end else if (narrow_right) begin
          bracket_right <= current_probe;
          right_fvalue  <= pv_q;
        end else begin
          bracket_left <= current_probe;
          left_fvalue  <= pv_q;
        end
      end
      S_NEXT: begin
        res_point  <= current_probe;
        res_iter   <= iter_count;
        res_status <= ST_LIMIT;
      end
      S_LAUNCH: begin
        if (cfg.method == METHOD_BISECT) begin
          previous_probe <= current_probe;
          current_probe  <= mid_point;
          res_point      <= mid_point;
          res_iter       <= iter_count;
          res_status     <= ST_PROBE;
        end
      end
      S_FPOS: begin
        if (fp_stat.done) begin
          res_iter <= iter_count;
          if (fp_stat.flat) begin
            res_point  <= start_q ? '0 : current_probe;
            res_status <= ST_FLAT;
          end else begin
            previous_probe <= current_probe;
            current_probe  <= fp_point;
            res_point      <= fp_point;
            res_status     <= ST_PROBE;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_point  <= res_point;
          out_status <= res_status;
          out_iter   <= res_iter;
        end
      end
      default: begin
      end
    endcase
  end

  assign result.valid       = out_valid;
  assign result.probe_point = out_point;
  assign result.status      = out_status;
  assign result.iteration   = out_iter;

  // An accepted beat is always examined in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> state == S_CHECK)
    else $error("accepted beat not followed by check state");

  // The false-position unit only finishes while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    fp_stat.done |-> state == S_FPOS)
    else $error("false-position completion outside wait state");

  // The output register is only loaded from the emit state.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_EMIT)
    else $error("result beat appeared without emit state");

  // An idle report carries no point and no iteration count.
  assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status == ST_IDLE) |->
      (result.probe_point == '0 && result.iteration == '0))
    else $error("idle result with nonzero payload");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench of the bracketing root finder core.
`timescale 1ns / 1ps

module tb_top;
  import brf_pkg::*;

  localparam int VW = VALUE_WIDTH_DEF;
  localparam longint VAL_MAX = (64'sd1 <<< (VW - 1)) - 1;
  localparam longint VAL_MIN = -(64'sd1 <<< (VW - 1));
  localparam longint HALVING = 2;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 200;

  typedef logic signed [VW-1:0] word_t;
  typedef longint unsigned ulong_t;

  localparam word_t WORD_MAX = word_t'(VAL_MAX);
  localparam word_t WORD_MIN = word_t'(VAL_MIN);

  // One input beat; tracked probe beats take their value from a test curve.
  typedef struct {
    bit     start_req;
    word_t  left_end;
    word_t  right_end;
    word_t  left_value;
    word_t  right_value;
    word_t  probe_value;
    bit     track;
    longint root;
    int     shape;
    bit     flip;
  } item_t;

  typedef struct {
    word_t          point;
    status_t        status;
    logic [ITER_W-1:0] iteration;
  } answer_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  brf_in_if  #(.W(VW)) item_ch ();
  brf_out_if #(.W(VW)) result_ch ();

  bracketing_root_finder_core #(.VALUE_WIDTH(VW)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  // Predicted configuration, mirrored at every register write.
  method_t           cfg_method    = METHOD_BISECT;
  logic [TOL_W-1:0]  cfg_tol_value = TOL_RESET;
  logic [TOL_W-1:0]  cfg_tol_step  = TOL_RESET;
  logic [ITER_W-1:0] cfg_max_iter  = MAX_ITER_RESET;

  // Predicted search state.
  longint            br_left    = 0;
  longint            br_right   = 0;
  longint            f_left     = 0;
  longint            f_right    = 0;
  longint            probe_cur  = 0;
  longint            probe_prev = 0;
  logic [ITER_W-1:0] iters      = '0;
  bit                solving    = 1'b0;

  item_t   items_pending[$];
  answer_t answers_due[$];
  item_t   on_wire;
  bit      holding = 1'b0;
  int      send_idle_pct = 0;
  int      stall_pct = 0;
  int      faults = 0;
  int      quiet_cycles = 0;

  function automatic ulong_t magnitude(longint x);
    return (x < 0) ? ulong_t'(-x) : ulong_t'(x);
  endfunction

  function automatic bit opposite_signs(longint x, longint y);
    return (x < 0 && y > 0) || (x > 0 && y < 0);
  endfunction

  // Midpoint rounded toward minus infinity.
  function automatic longint bisect_point(longint a, longint b);
    longint s;
    s = a + b;
    return (s < 0) ? (s - 1) / HALVING : s / HALVING;
  endfunction

  // False-position point with an exact numerator, truncated quotient and
  // saturation. Returns 0 when the two end values are equal.
  function automatic bit fpos_point(input longint a, input longint b, input longint fa,
                                    input longint fb, output longint pt);
    ulong_t m1, m2, nm, dm, q;
    bit     n1, n2, nn, neg;
    longint den;
    m1 = magnitude(a) * magnitude(fb);
    n1 = (a < 0) != (fb < 0);
    m2 = magnitude(b) * magnitude(fa);
    n2 = (b < 0) == (fa < 0);
    den = fb - fa;
    pt = 0;
    if (den == 0) return 1'b0;
    if (n1 == n2) begin
      nm = m1 + m2;
      nn = n1;
    end else if (m1 >= m2) begin
      nm = m1 - m2;
      nn = n1;
    end else begin
      nm = m2 - m1;
      nn = n2;
    end
    dm = magnitude(den);
    q = nm / dm;
    neg = (nn != (den < 0)) && (q != 0);
    if (neg) pt = (q > ulong_t'(VAL_MAX)) ? VAL_MIN : -longint'(q);
    else pt = (q > ulong_t'(VAL_MAX)) ? VAL_MAX : longint'(q);
    return 1'b1;
  endfunction

  // Advances the predicted search by one accepted beat and returns the answer.
  function automatic answer_t advance_search(item_t it);
    answer_t ans;
    longint  a, b, fa, fb, fc, nxt;
    bit      fin;
    ans.point = '0;
    ans.status = ST_IDLE;
    ans.iteration = '0;
    nxt = 0;
    if (it.start_req) begin
      a = it.left_end;
      b = it.right_end;
      fa = it.left_value;
      fb = it.right_value;
      solving = 1'b0;
      iters = '0;
      if (a >= b) begin
        ans.status = ST_BAD_INTERVAL;
        return ans;
      end
      if (!opposite_signs(fa, fb)) begin
        ans.status = ST_SAME_SIGNS;
        return ans;
      end
      br_left = a;
      br_right = b;
      f_left = fa;
      f_right = fb;
      probe_prev = a;
      if (cfg_method == METHOD_FALSE_POS) begin
        if (!fpos_point(a, b, fa, fb, nxt)) begin
          ans.status = ST_FLAT;
          return ans;
        end
      end else begin
        nxt = bisect_point(a, b);
      end
      probe_cur = nxt;
      solving = 1'b1;
      ans.point = word_t'(nxt);
      ans.status = ST_PROBE;
      return ans;
    end

    // A probe value with nothing running changes nothing.
    if (!solving) return ans;

    fc = it.probe_value;
    if (magnitude(fc) < cfg_tol_value) fin = 1'b1;
    else if (cfg_method == METHOD_FALSE_POS) fin = magnitude(probe_cur - probe_prev) < cfg_tol_step;
    else fin = magnitude(br_right - br_left) < cfg_tol_step;
    if (fin) begin
      solving = 1'b0;
      ans.point = word_t'(probe_cur);
      ans.status = ST_DONE;
      ans.iteration = iters + 1'b1;
      return ans;
    end

    // Narrow the bracket on the side that keeps the sign change.
    if (opposite_signs(f_left, fc)) begin
      br_right = probe_cur;
      f_right = fc;
    end else begin
      br_left = probe_cur;
      f_left = fc;
    end
    iters = iters + 1'b1;
    ans.point = word_t'(probe_cur);
    ans.iteration = iters;
    if (iters >= cfg_max_iter) begin
      solving = 1'b0;
      ans.status = ST_LIMIT;
      return ans;
    end
    if (cfg_method == METHOD_FALSE_POS) begin
      if (!fpos_point(br_left, br_right, f_left, f_right, nxt)) begin
        solving = 1'b0;
        ans.status = ST_FLAT;
        return ans;
      end
    end else begin
      nxt = bisect_point(br_left, br_right);
    end
    probe_prev = probe_cur;
    probe_cur = nxt;
    ans.point = word_t'(nxt);
    ans.status = ST_PROBE;
    return ans;
  endfunction

  // Test curve: scaled distance to a root, with a flat band around it.
  function automatic word_t curve_at(longint x, longint root, int sh, bit flip);
    longint v;
    v = (x - root) >>> sh;
    if (flip) v = -v;
    if (v > VAL_MAX) v = VAL_MAX;
    else if (v < VAL_MIN) v = VAL_MIN;
    return word_t'(v);
  endfunction

  // Random word biased toward the extremes and small values.
  function automatic word_t rand_word();
    case ($urandom_range(7))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3, 4: return word_t'(int'($urandom_range(200)) - 100);
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic item_t make_item(bit s, word_t le, word_t re, word_t lv, word_t rv,
                                      word_t pv);
    item_t it;
    it.start_req = s;
    it.left_end = le;
    it.right_end = re;
    it.left_value = lv;
    it.right_value = rv;
    it.probe_value = pv;
    it.track = 1'b0;
    it.root = 0;
    it.shape = 0;
    it.flip = 1'b0;
    return it;
  endfunction

  // Appends one beat to the end of the pending queue.
  function automatic void add_item(item_t it);
    items_pending = {items_pending, it};
  endfunction

  // Mostly well-formed problems on a test curve, the rest noise beats.
  function automatic void queue_random(int goal);
    item_t  it;
    int     added, pick, k, n, sh;
    longint w, a, r;
    bit     fl;
    added = 0;
    while (added < goal) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        k = $urandom_range(31, 1);
        w = 1 + (longint'($urandom) & ((64'sd1 <<< k) - 1));
        a = longint'(word_t'($urandom));
        if (a + w > VAL_MAX) a = VAL_MAX - w;
        r = a + (longint'($urandom) % (w + 1));
        sh = $urandom_range(6);
        fl = $urandom_range(1);
        add_item(make_item(1'b1, word_t'(a), word_t'(a + w),
                           curve_at(a, r, sh, fl), curve_at(a + w, r, sh, fl),
                           rand_word()));
        n = $urandom_range(24, 1);
        added += n + 1;
        repeat (n) begin
          it = make_item(1'b0, rand_word(), rand_word(), rand_word(), rand_word(),
                         rand_word());
          // Now and then a probe value off the curve breaks the sequence.
          if ($urandom_range(9) != 0) begin
            it.track = 1'b1;
            it.root = r;
            it.shape = sh;
            it.flip = fl;
          end
          add_item(it);
        end
      end else begin
        add_item(make_item(pick < 85, rand_word(), rand_word(), rand_word(),
                           rand_word(), rand_word()));
        added++;
      end
    end
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_METHOD:    cfg_method = method_t'(val[0]);
      REG_TOL_VALUE: cfg_tol_value = val[TOL_W-1:0];
      REG_TOL_STEP:  cfg_tol_step = val[TOL_W-1:0];
      REG_MAX_ITER:  cfg_max_iter = val[ITER_W-1:0];
      default: begin
      end
    endcase
  endtask

  task automatic set_regs(method_t m, logic [TOL_W-1:0] tv, logic [TOL_W-1:0] ts,
                          logic [ITER_W-1:0] mi);
    write_reg(REG_METHOD, CFG_DATA_W'(m));
    write_reg(REG_TOL_VALUE, CFG_DATA_W'(tv));
    write_reg(REG_TOL_STEP, CFG_DATA_W'(ts));
    write_reg(REG_MAX_ITER, CFG_DATA_W'(mi));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every queued beat is accepted and answered, then lets the core settle.
  task automatic drain();
    while (items_pending.size() != 0 || holding || answers_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Input driver: predicts each accepted beat, then offers the next one.
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      item_ch.start_req <= 1'b0;
      item_ch.left_end <= '0;
      item_ch.right_end <= '0;
      item_ch.left_value <= '0;
      item_ch.right_value <= '0;
      item_ch.probe_value <= '0;
      holding = 1'b0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        answers_due = {answers_due, advance_search(on_wire)};
        holding = 1'b0;
      end
      if (!holding) begin
        if (items_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_wire = items_pending.pop_front();
          if (on_wire.track && !on_wire.start_req)
            on_wire.probe_value = curve_at(probe_cur, on_wire.root, on_wire.shape,
                                           on_wire.flip);
          holding = 1'b1;
          item_ch.valid <= 1'b1;
          item_ch.start_req <= on_wire.start_req;
          item_ch.left_end <= on_wire.left_end;
          item_ch.right_end <= on_wire.right_end;
          item_ch.left_value <= on_wire.left_value;
          item_ch.right_value <= on_wire.right_value;
          item_ch.probe_value <= on_wire.probe_value;
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each result beat against the oldest answer due.
  always @(posedge clk) begin : check_results
    answer_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (answers_due.size() == 0) begin
          $error("result beat with no answer due: status %0d", result_ch.status);
          faults++;
        end else begin
          want = answers_due.pop_front();
          if (result_ch.probe_point !== want.point) begin
            $error("probe_point: expected %0d, got %0d", want.point, result_ch.probe_point);
            faults++;
          end
          if (result_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result_ch.status);
            faults++;
          end
          if (result_ch.iteration !== want.iteration) begin
            $error("iteration: expected %0d, got %0d", want.iteration, result_ch.iteration);
            faults++;
          end
        end
      end
      result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no beat accepted for %0d cycles", quiet_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_METHOD;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration, bisection: directed corner cases, then random, no idling.
    add_item(make_item(1'b0, 0, 0, 0, 0, WORD_MIN));
    add_item(make_item(1'b1, 5, 5, -1, 1, 0));
    add_item(make_item(1'b1, WORD_MAX, WORD_MIN, -1, 1, 0));
    add_item(make_item(1'b1, 0, 100, 0, 5, 0));
    add_item(make_item(1'b1, 0, 100, 3, 7, 0));
    add_item(make_item(1'b1, 0, 100, -3, WORD_MIN, 0));
    add_item(make_item(1'b1, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, 0));
    add_item(make_item(1'b0, 0, 0, 0, 0, WORD_MAX));
    add_item(make_item(1'b0, 0, 0, 0, 0, WORD_MIN));
    // Restart in the middle of a problem, then the value tolerance boundary.
    add_item(make_item(1'b1, -70000, 3, -1000, 1000, 0));
    add_item(make_item(1'b0, 0, 0, 0, 0, 66));
    add_item(make_item(1'b0, 0, 0, 0, 0, -66));
    add_item(make_item(1'b0, 0, 0, 0, 0, -65));
    add_item(make_item(1'b0, 0, 0, 0, 0, 7));
    // Odd negative sum rounds down; a narrow bracket converges on width.
    add_item(make_item(1'b1, -5, 2, 1, -1, 0));
    add_item(make_item(1'b0, 0, 0, 0, 0, 1000));
    queue_random(140);
    drain();

    // Regula falsi at the reset tolerances.
    set_regs(METHOD_FALSE_POS, TOL_RESET, TOL_RESET, MAX_ITER_RESET);
    queue_random(155);
    drain();

    // Tightest nonzero tolerances, longest iteration limit, idle sender.
    send_idle_pct = 87;
    set_regs(METHOD_BISECT, TOL_W'(1), TOL_W'(1), 16'hFFFF);
    queue_random(155);
    drain();

    // Zero tolerances: a flat bracket and a saturated false-position point.
    set_regs(METHOD_FALSE_POS, TOL_W'(0), TOL_W'(0), 16'hFFFF);
    add_item(make_item(1'b1, 0, 1000, -100, 100, 0));
    add_item(make_item(1'b0, 0, 0, 0, 0, 0));
    add_item(make_item(1'b0, 0, 0, 0, 0, 100));
    add_item(make_item(1'b1, WORD_MIN, WORD_MAX, -1, 1, 0));
    add_item(make_item(1'b0, 0, 0, 0, 0, 0));
    add_item(make_item(1'b0, 0, 0, 0, 0, 2));
    add_item(make_item(1'b0, 0, 0, 0, 0, -5));
    queue_random(150);
    drain();

    // Widest tolerances and an iteration limit of one, stalling receiver.
    send_idle_pct = 0;
    stall_pct = 87;
    set_regs(METHOD_BISECT, {TOL_W{1'b1}}, {TOL_W{1'b1}}, ITER_W'(1));
    queue_random(155);
    drain();

    // A zero iteration limit ends every problem at its first probe value.
    set_regs(METHOD_FALSE_POS, TOL_W'(0), TOL_W'(0), ITER_W'(0));
    queue_random(155);
    drain();

    // Random tolerances with short limits, both sides idling.
    send_idle_pct = 23;
    stall_pct = 23;
    set_regs(METHOD_FALSE_POS, TOL_W'($urandom_range(200000, 50)),
             TOL_W'($urandom_range(200000, 50)), ITER_W'(20));
    queue_random(155);
    drain();

    set_regs(METHOD_BISECT, TOL_W'($urandom_range(200000, 50)),
             TOL_W'($urandom_range(200000, 50)), ITER_W'(8));
    queue_random(155);
    drain();

    // Step tolerance at its maximum in regula falsi, no idling.
    send_idle_pct = 0;
    stall_pct = 0;
    set_regs(METHOD_FALSE_POS, TOL_W'(1), {TOL_W{1'b1}}, 16'hFFFF);
    queue_random(150);
    drain();

    if (faults == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
